FILE: rtl/aisd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisd_pkg: shared types and constants of the AIS position report decoder
// Status codes, payload store geometry, length limits and the de-armor
// function used by the decoder modules.
// ----------------------------------------------------------------------------
package aisd_pkg;

  // Report status, in rising priority
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_NOT_POS  = 2'd2,
    ST_BAD_CHAR = 2'd3
  } status_t;

  // Only the first 24 characters carry bits that any report field uses
  localparam int STORE_CHARS = 24;
  localparam int STORE_BITS  = STORE_CHARS * 6;
  localparam int CNT_W       = 7;
  localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
  localparam logic [CNT_W-1:0] LEN_SHORT = 7'd28;
  localparam logic [CNT_W-1:0] LEN_LONG  = 7'd52;

  // Message types of interest
  localparam logic [5:0] TYPE_CLASS_B_STD = 6'd18;
  localparam logic [5:0] TYPE_CLASS_B_EXT = 6'd19;

  // Armor character ranges
  localparam logic [7:0] ARM_LO_MIN = 8'd48;
  localparam logic [7:0] ARM_LO_MAX = 8'd87;
  localparam logic [7:0] ARM_HI_MIN = 8'd96;
  localparam logic [7:0] ARM_HI_MAX = 8'd119;
  localparam logic [7:0] ARM_HI_OFS = 8'd56;

  // Field defaults for class B reports
  localparam logic [3:0] NAV_NONE = 4'd15;
  localparam logic [7:0] ROT_NONE = 8'h80;

  // One decoded report
  typedef struct packed {
    status_t            status;
    logic [5:0]         message_type;
    logic [29:0]        mmsi;
    logic [3:0]         nav_status;
    logic signed [7:0]  rate_of_turn;
    logic [9:0]         speed_over_ground;
    logic               position_accuracy;
    logic signed [27:0] longitude;
    logic signed [26:0] latitude;
    logic [11:0]        course_over_ground;
    logic [8:0]         true_heading;
    logic [5:0]         time_stamp;
  } aisd_report_t;

  // De-armor one ASCII character; bit 6 flags a valid character
  function automatic logic [6:0] dearmor(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= ARM_LO_MIN && c <= ARM_LO_MAX) begin
        d = c - ARM_LO_MIN;
        dearmor = {1'b1, d[5:0]};
      end else if (c >= ARM_HI_MIN && c <= ARM_HI_MAX) begin
        d = c - ARM_HI_OFS;
        dearmor = {1'b1, d[5:0]};
      end else begin
        dearmor = 7'd0;
      end
    end
  endfunction

endpackage

FILE: rtl/aisd_fields.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisd_fields: report field extraction
// Classifies the message, picks the status and slices every report field
// out of the payload bits at the type 1-3 or type 18/19 offsets.
// ----------------------------------------------------------------------------
module aisd_fields (
  input  logic [aisd_pkg::STORE_BITS-1:0] flat_bits,   // payload bit p at [STORE_BITS-1-p]
  input  logic [5:0]                      msg_type,
  input  logic [aisd_pkg::CNT_W-1:0]      char_count,
  input  logic                            bad_char,
  output aisd_pkg::aisd_report_t          report
);
  import aisd_pkg::*;

  localparam int TOP = STORE_BITS - 1;

  logic cls_a;
  logic cls_b;
  logic [CNT_W-1:0] want_len;
  logic [TOP:0] sel_bits;   // bits aligned to type 1-3 offsets

  always_comb begin
    cls_a    = (msg_type != 6'd0) && (msg_type <= 6'd3);
    cls_b    = (msg_type == TYPE_CLASS_B_STD) || (msg_type == TYPE_CLASS_B_EXT);
    want_len = (msg_type == TYPE_CLASS_B_EXT) ? LEN_LONG : LEN_SHORT;
    // class B fields sit four bits earlier; shift them onto the class A slots
    sel_bits = cls_b ? {4'b0, flat_bits[TOP:4]} : flat_bits;
  end

  always_comb begin
    report              = '0;
    report.message_type = msg_type;
    priority if (bad_char)           report.status = ST_BAD_CHAR;
    else if (!cls_a && !cls_b)       report.status = ST_NOT_POS;
    else if (char_count != want_len) report.status = ST_BAD_LEN;
    else                             report.status = ST_OK;

    if (!bad_char && (cls_a || cls_b)) begin
      report.mmsi = flat_bits[TOP-8 -: 30];
      if (cls_a) begin
        report.nav_status   = flat_bits[TOP-38 -: 4];
        report.rate_of_turn = flat_bits[TOP-42 -: 8];
      end else begin
        report.nav_status   = NAV_NONE;
        report.rate_of_turn = ROT_NONE;
      end
      report.speed_over_ground  = sel_bits[TOP-50 -: 10];
      report.position_accuracy  = sel_bits[TOP-60];
      report.longitude          = sel_bits[TOP-61 -: 28];
      report.latitude           = sel_bits[TOP-89 -: 27];
      report.course_over_ground = sel_bits[TOP-116 -: 12];
      report.true_heading       = sel_bits[TOP-128 -: 9];
      report.time_stamp         = sel_bits[TOP-137 -: 6];
    end
  end

endmodule

FILE: rtl/ais_position_report_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_position_report_decoder: AIS position report payload decoder
// Collects armored payload characters and emits one decoded report per
// payload on the character marked last.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while the input is not stalled. Each
// accepted character is de-armored into an input register, then written into
// the payload store on the next cycle; the character flagged by in_tlast is
// instead merged with the store into the report register, so a report passes
// through the input register and then the report register. A waiting report
// stalls the input only when a further last character arrives behind it. The
// store and counters clear after every report. out_tuser carries the status:
// 0 ok, 1 wrong length, 2 not a position report, 3 bad character.
module ais_position_report_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] char_code
  input  logic         in_tlast,    // last_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,   // [5:0] message_type, [35:6] mmsi,
                                    // [39:36] nav_status, [47:40] rate_of_turn,
                                    // [57:48] speed_over_ground,
                                    // [58] position_accuracy, [86:59] longitude,
                                    // [113:87] latitude,
                                    // [125:114] course_over_ground,
                                    // [134:126] true_heading, [140:135] time_stamp
  output logic [1:0]   out_tuser    // [1:0] status
);
  import aisd_pkg::*;

  // Input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [5:0] s1_val_r;
  logic       s1_ok_r;
  logic       s1_last_r;
  logic [6:0] arm;
  logic       s1_go;
  logic       in_xfer;

  // Payload state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [5:0]       type_r, type_nxt;
  logic             bad_r, bad_nxt;
  logic [5:0]       chars_r [STORE_CHARS];
  logic [5:0]       chars_m [STORE_CHARS];
  logic [STORE_BITS-1:0] flat;
  logic [CNT_W-1:0] count_inc;

  // Output stage
  logic         out_valid_r, out_valid_nxt;
  aisd_report_t rep;
  aisd_report_t rep_r;

  // Handshake
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;
  assign arm       = dearmor(in_tdata);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer)    s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_xfer) begin
      s1_val_r  <= arm[5:0];
      s1_ok_r   <= arm[6];
      s1_last_r <= in_tlast;
    end
  end

  // Merge the current character into the payload view
  always_comb begin
    count_inc = (count_r == CNT_MAX) ? count_r : count_r + 7'd1;
    type_nxt  = (count_r == '0) ? s1_val_r : type_r;
    bad_nxt   = bad_r | ~s1_ok_r;
    for (int i = 0; i < STORE_CHARS; i++) begin
      chars_m[i] = (count_r == CNT_W'(i)) ? s1_val_r : chars_r[i];
      flat[(STORE_BITS-1-6*i) -: 6] = chars_m[i];
    end
    count_nxt = count_inc;
  end

  aisd_fields u_fields (
    .flat_bits (flat),
    .msg_type  (type_nxt),
    .char_count(count_inc),
    .bad_char  (bad_nxt),
    .report    (rep)
  );

  // Payload state update; a last character clears it for the next payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      type_r  <= '0;
      bad_r   <= 1'b0;
      for (int i = 0; i < STORE_CHARS; i++) chars_r[i] <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        count_r <= '0;
        type_r  <= '0;
        bad_r   <= 1'b0;
        for (int i = 0; i < STORE_CHARS; i++) chars_r[i] <= '0;
      end else begin
        count_r <= count_nxt;
        type_r  <= type_nxt;
        bad_r   <= bad_nxt;
        for (int i = 0; i < STORE_CHARS; i++) chars_r[i] <= chars_m[i];
      end
    end
  end

  // Report register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) out_valid_nxt = 1'b1;
    else if (out_tready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_go && s1_last_r) rep_r <= rep;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rep_r.status;
  assign out_tdata  = {3'b000,
                       rep_r.time_stamp,
                       rep_r.true_heading,
                       rep_r.course_over_ground,
                       rep_r.latitude,
                       rep_r.longitude,
                       rep_r.position_accuracy,
                       rep_r.speed_over_ground,
                       rep_r.rate_of_turn,
                       rep_r.nav_status,
                       rep_r.mmsi,
                       rep_r.message_type};

endmodule

FILE: sim/ais_position_report_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_position_report_decoder_test: self-checking bench for the AIS decoder
// Feeds armored payloads (directed corner payloads, then random well-formed,
// wrong-length, non-position and corrupted ones) through the input stream
// with bursty valid and a stalling receiver. A local decoder model predicts
// every report, which is checked field by field against the output stream.
// ----------------------------------------------------------------------------
module ais_position_report_decoder_test;
  import aisd_pkg::*;

  localparam int CHAR_TARGET = 1150;
  localparam int PAY_BITS    = 192;
  localparam int PAY_CHARS   = 32;

  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } char_item_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'd0;  // [7:0] char_code
  logic         in_tlast   = 1'b0;  // last_char
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;          // [5:0] type ... [140:135] time_stamp
  logic [1:0]   out_tuser;          // [1:0] status

  char_item_t   char_q[$];
  aisd_report_t report_q[$];

  // Local decoder state
  logic         pl_bits [0:PAY_BITS-1];
  logic [6:0]   pl_count = 7'd0;
  logic [5:0]   pl_type  = 6'd0;
  logic         pl_bad   = 1'b0;

  int n_err      = 0;
  int n_chars    = 0;
  int n_payloads = 0;
  int n_reports  = 0;
  int n_status [4];
  logic in_xfer  = 1'b0;
  int burst_left = 1;
  int gap_left   = 0;
  int rdy_cnt    = 0;
  int rdy_mode   = 0;

  ais_position_report_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void clear_payload();
    for (int i = 0; i < PAY_BITS; i++) pl_bits[i] = 1'b0;
    pl_count = 7'd0;
    pl_type  = 6'd0;
    pl_bad   = 1'b0;
  endfunction

  // Payload bits, first bit most significant
  function automatic logic [63:0] pl_field(input int start, input int len);
    logic [63:0] r;
    r = 64'd0;
    for (int i = 0; i < len; i++) r = {r[62:0], pl_bits[start + i]};
    return r;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic is_last);
    logic [7:0]   d;
    logic [5:0]   v;
    logic         ok;
    logic         cls_a;
    logic         cls_b;
    logic [6:0]   want_len;
    int           off;
    aisd_report_t r;
    ok = 1'b1;
    if (c >= ARM_LO_MIN && c <= ARM_LO_MAX) d = c - ARM_LO_MIN;
    else if (c >= ARM_HI_MIN && c <= ARM_HI_MAX) d = c - ARM_HI_OFS;
    else begin
      d  = 8'd0;
      ok = 1'b0;
    end
    v = d[5:0];
    if (!ok) pl_bad = 1'b1;
    if (pl_count == 7'd0) pl_type = v;
    if (pl_count < PAY_CHARS)
      for (int i = 0; i < 6; i++) pl_bits[pl_count * 6 + i] = v[5 - i];
    if (pl_count != CNT_MAX) pl_count = pl_count + 7'd1;
    if (!is_last) return;

    cls_a    = (pl_type >= 6'd1 && pl_type <= 6'd3);
    cls_b    = (pl_type == TYPE_CLASS_B_STD || pl_type == TYPE_CLASS_B_EXT);
    want_len = (pl_type == TYPE_CLASS_B_EXT) ? LEN_LONG : LEN_SHORT;
    r = '0;
    r.message_type = pl_type;
    if (pl_bad) r.status = ST_BAD_CHAR;
    else if (!cls_a && !cls_b) r.status = ST_NOT_POS;
    else if (pl_count != want_len) r.status = ST_BAD_LEN;
    else r.status = ST_OK;

    // Fields are decoded for good and wrong-length reports only
    if (r.status == ST_OK || r.status == ST_BAD_LEN) begin
      off    = cls_b ? 4 : 0;
      r.mmsi = 30'(pl_field(8, 30));
      if (cls_a) begin
        r.nav_status   = 4'(pl_field(38, 4));
        r.rate_of_turn = 8'(pl_field(42, 8));
      end else begin
        r.nav_status   = NAV_NONE;
        r.rate_of_turn = ROT_NONE;
      end
      r.speed_over_ground  = 10'(pl_field(50 - off, 10));
      r.position_accuracy  = 1'(pl_field(60 - off, 1));
      r.longitude          = 28'(pl_field(61 - off, 28));
      r.latitude           = 27'(pl_field(89 - off, 27));
      r.course_over_ground = 12'(pl_field(116 - off, 12));
      r.true_heading       = 9'(pl_field(128 - off, 9));
      r.time_stamp         = 6'(pl_field(137 - off, 6));
    end
    report_q.push_back(r);
    clear_payload();
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] armor(input logic [5:0] v);
    return (v < 6'd40) ? 8'(v) + ARM_LO_MIN : 8'(v) + ARM_HI_OFS;
  endfunction

  // Any code outside both armor ranges
  function automatic logic [7:0] bad_code();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 47));
      1:       return 8'($urandom_range(88, 95));
      default: return 8'($urandom_range(120, 255));
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c, input logic is_last);
    char_item_t it;
    it.code    = c;
    it.is_last = is_last;
    char_q.push_back(it);
    n_chars++;
    if (is_last) n_payloads++;
  endtask

  // fill: 0 all zeros, 1 all ones, else random body; bad_pos < 0 means clean
  task automatic push_payload(input logic [5:0] typ, input int len, input int fill,
                              input int bad_pos);
    logic [5:0] v;
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (i == 0) v = typ;
      else if (fill == 0) v = 6'd0;
      else if (fill == 1) v = 6'd63;
      else v = 6'($urandom_range(0, 63));
      c = (i == bad_pos) ? bad_code() : armor(v);
      push_char(c, i == len - 1);
    end
  endtask

  function automatic logic [5:0] pos_type();
    case ($urandom_range(0, 4))
      0:       return 6'd1;
      1:       return 6'd2;
      2:       return 6'd3;
      3:       return TYPE_CLASS_B_STD;
      default: return TYPE_CLASS_B_EXT;
    endcase
  endfunction

  task automatic build_stimulus();
    logic [5:0] t;
    int         len;
    int         sel;
    int         fill;
    // Directed corner payloads
    push_char(armor(6'd0), 1'b1);                 // type zero
    push_char(8'hFF, 1'b1);                       // bad first character
    push_char(armor(6'd63), 1'b1);                // top type, not a report
    push_char(armor(6'd1), 1'b1);                 // class A, one character
    push_char(armor(TYPE_CLASS_B_STD), 1'b1);     // class B defaults, short
    push_char(armor(TYPE_CLASS_B_EXT), 1'b1);
    push_char(armor(6'd2), 1'b0);                 // armor range edges
    push_char(ARM_LO_MIN, 1'b0);
    push_char(ARM_LO_MAX, 1'b0);
    push_char(ARM_HI_MIN, 1'b0);
    push_char(ARM_HI_MAX, 1'b1);
    push_char(armor(6'd3), 1'b0);                 // just outside each edge
    push_char(ARM_LO_MIN - 8'd1, 1'b1);
    push_char(ARM_LO_MAX + 8'd1, 1'b1);
    push_char(ARM_HI_MIN - 8'd1, 1'b1);
    push_char(ARM_HI_MAX + 8'd1, 1'b1);
    // Counter saturation: one very long class A payload
    push_payload(6'd1, 130, 2, -1);
    // Random payloads
    while (n_chars < CHAR_TARGET) begin
      sel  = $urandom_range(0, 99);
      fill = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : 2;
      t    = pos_type();
      len  = (t == TYPE_CLASS_B_EXT) ? int'(LEN_LONG) : int'(LEN_SHORT);
      if (sel < 60) begin
        push_payload(t, len, fill, -1);
      end else if (sel < 75) begin
        len = (sel == 60) ? $urandom_range(120, 135) : $urandom_range(1, 60);
        push_payload(t, len, fill, -1);
      end else if (sel < 85) begin
        do t = 6'($urandom_range(0, 63));
        while ((t >= 6'd1 && t <= 6'd3) || t == TYPE_CLASS_B_STD ||
               t == TYPE_CLASS_B_EXT);
        push_payload(t, $urandom_range(1, 40), fill, -1);
      end else begin
        push_payload(t, len, fill, $urandom_range(0, len - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin : drive_chars
    char_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_xfer) begin
      // hold the pending transfer
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (char_q.size() > 0) begin
      it = char_q.pop_front();
      in_tdata  <= it.code;
      in_tlast  <= it.is_last;
      in_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver stall pattern in one of four randomly picked modes
  always @(negedge clk) begin
    rdy_cnt <= rdy_cnt + 1;
    if (rdy_cnt % 50 == 0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rdy_cnt % 8) < 3;
      default: out_tready <= (rdy_cnt % 32) == 0;
    endcase
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(input string fld, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH report %0d %s: got 0x%0h, expected 0x%0h",
             n_reports, fld, got, want);
    n_err++;
  endtask

  task automatic check_report();
    aisd_report_t e;
    if (report_q.size() == 0) begin
      $display("MISMATCH unexpected report, status %0d type %0d",
               out_tuser, out_tdata[5:0]);
      n_err++;
      return;
    end
    e = report_q.pop_front();
    n_status[out_tuser]++;
    if (out_tuser != e.status) report_mismatch("status", out_tuser, e.status);
    if (out_tdata[5:0] != e.message_type)
      report_mismatch("message_type", out_tdata[5:0], e.message_type);
    if (out_tdata[35:6] != e.mmsi) report_mismatch("mmsi", out_tdata[35:6], e.mmsi);
    if (out_tdata[39:36] != e.nav_status)
      report_mismatch("nav_status", out_tdata[39:36], e.nav_status);
    if (out_tdata[47:40] != $unsigned(e.rate_of_turn))
      report_mismatch("rate_of_turn", out_tdata[47:40], $unsigned(e.rate_of_turn));
    if (out_tdata[57:48] != e.speed_over_ground)
      report_mismatch("speed_over_ground", out_tdata[57:48], e.speed_over_ground);
    if (out_tdata[58] != e.position_accuracy)
      report_mismatch("position_accuracy", out_tdata[58], e.position_accuracy);
    if (out_tdata[86:59] != $unsigned(e.longitude))
      report_mismatch("longitude", out_tdata[86:59], $unsigned(e.longitude));
    if (out_tdata[113:87] != $unsigned(e.latitude))
      report_mismatch("latitude", out_tdata[113:87], $unsigned(e.latitude));
    if (out_tdata[125:114] != e.course_over_ground)
      report_mismatch("course_over_ground", out_tdata[125:114], e.course_over_ground);
    if (out_tdata[134:126] != e.true_heading)
      report_mismatch("true_heading", out_tdata[134:126], e.true_heading);
    if (out_tdata[140:135] != e.time_stamp)
      report_mismatch("time_stamp", out_tdata[140:135], e.time_stamp);
    if (out_tdata[143:141] != 3'd0)
      report_mismatch("tdata padding", out_tdata[143:141], 0);
    n_reports++;
  endtask

  // Check reports and predict from accepted characters at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) decode_char(in_tdata, in_tlast);
      in_xfer <= in_tvalid && in_tready;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    for (int i = 0; i < 4; i++) n_status[i] = 0;
    clear_payload();
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (char_q.size() > 0 || in_tvalid) @(posedge clk);
    while (report_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d characters in %0d payloads, checked %0d reports",
             n_chars, n_payloads, n_reports);
    $display("Status mix: ok %0d, wrong length %0d, not position %0d, bad char %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
